FILE: rtl/core/rle_pkg.sv
// Shared constants and types for the redundant load eliminator.
// No dependencies; imported by rle_scan, redundant_load_eliminator, rle_checker and testbench.
package rle_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Instruction classes
  localparam logic [2:0] OP_OTHER       = 3'd0;
  localparam logic [2:0] OP_FLUSH       = 3'd1;
  localparam logic [2:0] OP_STORE_TEMP  = 3'd2;
  localparam logic [2:0] OP_STORE_OTHER = 3'd3;
  localparam logic [2:0] OP_LOAD        = 3'd4;

  // One table entry as stored in RAM
  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] temp;
    logic        valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Scan unit result, valid in the cycle done is high
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [15:0]      temp;
  } scan_res_t;

endpackage

FILE: rtl/core/rle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rle_scan.sv
// Table walk sequencer: reads entries in order, one per cycle, and stops at
// the first valid entry whose offset matches. Depends on rle_pkg.
module rle_scan
  import rle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [15:0]      key_in,
  input  logic [CNT_W-1:0] count,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  entry_t           rd_data,
  output logic             busy,
  output scan_res_t        res
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] scan_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [15:0]      key;
  logic             issue;
  logic             match;
  logic             done;

  // read pipelined ahead of the compare: the compare sees registered read data
  assign issue = (state == S_SCAN) && (scan_idx < count);
  assign match = pend && rd_data.valid && (rd_data.offset == key);
  assign done  = (state == S_SCAN) && (match || !issue);

  assign rd_en   = issue && !match;
  assign rd_addr = scan_idx[IDX_W-1:0];
  assign busy    = (state == S_SCAN);

  assign res.done = done;
  assign res.hit  = match;
  assign res.idx  = pend_idx;
  assign res.temp = rd_data.temp;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (go) state_next = S_SCAN;
      S_SCAN: if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        pend <= 1'b0;
      end else begin
        pend <= issue && !done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && go) begin
      key      <= key_in;
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    pend_idx <= scan_idx[IDX_W-1:0];
  end

endmodule

FILE: rtl/core/redundant_load_eliminator.sv
// Redundant load eliminator top level: item latch, table count, result
// register. Depends on rle_pkg, rle_ram and rle_scan.
//
// Usage: drive opcode, slot_offset, temp_id and last_of_function with start
// high; the beat is taken at a clock edge where start is high and busy low.
// Every accepted beat gives exactly one result beat on becomes_move and
// move_source_temp, marked by result_strobe for one cycle; the receiver
// cannot stall it.
// Latency: "other", flush, and any search op on an empty table give their
// result the cycle after acceptance, and a new beat may be taken every cycle.
// Stores and loads walk the filled entries through the single RAM read port,
// one entry a cycle with the compare on the registered read data, up to all
// 256 entries of a full table; busy stays high for the whole walk, so no new
// beat is taken before it resolves, and the result is registered after that.
// A hit stops the walk early. Table updates and appends happen in the cycle
// the item resolves, through the RAM write port.
// Reset empties the table (entry count to zero); the RAM itself is never
// cleared since entries at or above the count are never read.
module redundant_load_eliminator
  import rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic signed [15:0] slot_offset,
  input  logic [15:0]        temp_id,
  input  logic               last_of_function,
  output logic               result_strobe,
  output logic               becomes_move,
  output logic [15:0]        move_source_temp
);

  logic [CNT_W-1:0] count, count_next;
  logic [2:0]       op_q;
  logic [15:0]      off_q;
  logic [15:0]      temp_q;
  logic             last_q;

  logic             accept;
  logic             search_op;
  logic             scan_go;
  logic             imm;
  logic             finish;
  logic             scan_busy;
  scan_res_t        sres;

  // current item as seen at finish time
  logic [2:0]       op_f;
  logic [15:0]      off_f;
  logic [15:0]      temp_f;
  logic             last_f;
  logic             hit_f;
  logic             full;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             appended;
  logic             move_next;
  logic [15:0]      src_next;

  assign busy      = scan_busy;
  assign accept    = start && !busy;
  assign search_op = (opcode == OP_STORE_TEMP) || (opcode == OP_STORE_OTHER) ||
                     (opcode == OP_LOAD);
  assign scan_go   = accept && search_op && (count != '0);
  assign imm       = accept && !scan_go;
  assign finish    = imm || sres.done;

  assign op_f   = imm ? opcode : op_q;
  assign off_f  = imm ? slot_offset : off_q;
  assign temp_f = imm ? temp_id : temp_q;
  assign last_f = imm ? last_of_function : last_q;
  assign hit_f  = !imm && sres.hit;
  assign full   = (count == CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      off_q  <= slot_offset;
      temp_q <= temp_id;
      last_q <= last_of_function;
    end
  end

  rle_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .go      (scan_go),
    .key_in  (slot_offset),
    .count   (count),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (scan_busy),
    .res     (sres)
  );

  rle_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Resolve the item: table write, count update, result
  always_comb begin
    we        = 1'b0;
    waddr     = sres.idx;
    wdata     = '{offset: off_f, temp: temp_f, valid: 1'b1};
    appended  = 1'b0;
    move_next = 1'b0;
    src_next  = '0;
    if (finish) begin
      unique case (op_f) inside
        OP_STORE_TEMP, OP_LOAD: begin
          if (hit_f) begin
            we = 1'b1;
            if (op_f == OP_LOAD) begin
              move_next = 1'b1;
              src_next  = sres.temp;
            end
          end else if (!full) begin
            we       = 1'b1;
            waddr    = count[IDX_W-1:0];
            appended = 1'b1;
          end
        end
        OP_STORE_OTHER: begin
          if (hit_f) begin
            we    = 1'b1;
            wdata = '{offset: off_f, temp: sres.temp, valid: 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (finish) begin
      if (appended) count_next = count + 1'b1;
      if (op_f == OP_FLUSH || last_f) count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      count         <= count_next;
      result_strobe <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      becomes_move     <= move_next;
      move_source_temp <= src_next;
    end
  end

  // Checks
  a_strobe_follows_finish: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(finish))
    else $error("result beat without a resolved item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count past table size");

  a_no_strobe_while_walking: assert property (@(posedge clk) disable iff (rst)
    busy |-> !result_strobe)
    else $error("result beat during a table walk");

  a_count_steady_in_walk: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> $stable(count))
    else $error("entry count changed during a walk");

endmodule

FILE: sim/rle_checker.sv
// Checker for the redundant load eliminator: watches both channels, keeps a
// shadow copy of the slot table and compares every result beat.
// Depends on rle_pkg; instantiated by the testbench top.
`timescale 1ns / 1ps

module rle_checker
  import rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         opcode,
  input  logic signed [15:0] slot_offset,
  input  logic [15:0]        temp_id,
  input  logic               last_of_function,
  input  logic               result_strobe,
  input  logic               becomes_move,
  input  logic [15:0]        move_source_temp,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic        becomes_move;
    logic [15:0] move_source_temp;
  } move_t;

  logic [15:0] shadow_offset [TABLE_ENTRIES];
  logic [15:0] shadow_temp   [TABLE_ENTRIES];
  bit          shadow_live   [TABLE_ENTRIES];
  int          shadow_count;
  move_t       pending_moves [$];

  // first live entry holding this slot, -1 if none
  function automatic int find_live(input logic [15:0] off);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_live[i] && shadow_offset[i] == off) return i;
    return -1;
  endfunction

  // full table: the new entry is dropped
  function automatic void append_entry(input logic [15:0] off, input logic [15:0] tmp);
    if (shadow_count < TABLE_ENTRIES) begin
      shadow_offset[shadow_count] = off;
      shadow_temp[shadow_count]   = tmp;
      shadow_live[shadow_count]   = 1'b1;
      shadow_count++;
    end
  endfunction

  function automatic move_t predict_move(input logic [2:0] op, input logic [15:0] off,
                                         input logic [15:0] tmp, input logic last);
    move_t res;
    int    idx;
    res = '0;
    case (op)
      OP_FLUSH: shadow_count = 0;
      OP_STORE_TEMP: begin
        idx = find_live(off);
        if (idx >= 0) shadow_temp[idx] = tmp;
        else append_entry(off, tmp);
      end
      OP_STORE_OTHER: begin
        idx = find_live(off);
        if (idx >= 0) shadow_live[idx] = 1'b0;
      end
      OP_LOAD: begin
        idx = find_live(off);
        if (idx >= 0) begin
          res.becomes_move     = 1'b1;
          res.move_source_temp = shadow_temp[idx];
          shadow_temp[idx]     = tmp;
        end else begin
          append_entry(off, tmp);
        end
      end
      default: ;
    endcase
    if (last) shadow_count = 0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    move_t want;
    if (rst) begin
      shadow_count = 0;
      pending_moves.delete();
      fail_count = 0;
    end else begin
      // result first: a beat accepted at this edge cannot have its result yet
      if (result_strobe) begin
        if (pending_moves.size() == 0) begin
          $error("result beat with no instruction outstanding");
          fail_count++;
        end else begin
          want = pending_moves.pop_front();
          if (becomes_move !== want.becomes_move) begin
            $error("becomes_move: expected %0h, got %0h", want.becomes_move, becomes_move);
            fail_count++;
          end
          if (move_source_temp !== want.move_source_temp) begin
            $error("move_source_temp: expected %0h, got %0h",
                   want.move_source_temp, move_source_temp);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        pending_moves.push_back(predict_move(opcode, slot_offset, temp_id, last_of_function));
    end
    pending = pending_moves.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the redundant load eliminator testbench: clock, reset, instruction
// stimulus, watchdog and verdict. Depends on rle_pkg, rle_checker and the RTL.
`timescale 1ns / 1ps

module testbench
  import rle_pkg::*;
();

  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 4000;  // must outlast a full-table walk
  localparam int DRAIN_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         opcode;
  logic signed [15:0] slot_offset;
  logic [15:0]        temp_id;
  logic               last_of_function;
  logic               result_strobe;
  logic               becomes_move;
  logic [15:0]        move_source_temp;

  int fail_count;
  int pending;
  int idle_cycles;
  int random_items;
  bit burst_mode;   // no gaps at all for the current function
  bit fill_done;

  always #1 clk = ~clk;

  redundant_load_eliminator dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .slot_offset      (slot_offset),
    .temp_id          (temp_id),
    .last_of_function (last_of_function),
    .result_strobe    (result_strobe),
    .becomes_move     (becomes_move),
    .move_source_temp (move_source_temp)
  );

  rle_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .slot_offset      (slot_offset),
    .temp_id          (temp_id),
    .last_of_function (last_of_function),
    .result_strobe    (result_strobe),
    .becomes_move     (becomes_move),
    .move_source_temp (move_source_temp),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge. When no gap follows,
  // start stays high and the caller must present the next beat or lower start
  // in the same step, so nothing is accepted twice. busy only moves at rising
  // edges, so its value at the falling edge is the one the next edge sees.
  task automatic send_beat(input logic [2:0] op, input logic [15:0] off,
                           input logic [15:0] tmp, input logic last);
    int gap;
    opcode           = op;
    slot_offset      = off;
    temp_id          = tmp;
    last_of_function = last;
    start            = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    random_items++;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain();
    start = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One function body: loads and stores over a small set of slots so that
  // hits, updates and invalidations are common; some noise mixed in. Most
  // end with last_of_function, a few run on into the next one.
  task automatic run_function();
    logic [15:0] pool [8];
    logic [2:0]  op;
    logic [15:0] off;
    logic        last;
    int          pool_n, len, r;
    bit          ends;
    pool_n     = $urandom_range(1, 8);
    len        = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
    ends       = ($urandom_range(0, 9) != 0);
    burst_mode = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < pool_n; k++) pool[k] = pick_offset();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      op = OP_LOAD;
      else if (r < 70) op = OP_STORE_TEMP;
      else if (r < 82) op = OP_STORE_OTHER;
      else if (r < 88) op = OP_OTHER;
      else if (r < 91) op = OP_FLUSH;
      else             op = 3'($urandom_range(5, 7));  // unused codes act as "other"
      off  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, pool_n - 1)];
      last = (i == len - 1) ? ends : ($urandom_range(0, 49) == 0);
      send_beat(op, off, 16'($urandom), last);
    end
  endtask

  // Fill the table past capacity with distinct slots, then check that new
  // entries are dropped while the old ones still hit. An invalidated entry
  // keeps its place, so a store to a fresh slot is still dropped after it.
  task automatic fill_table();
    logic [15:0] base;
    base       = 16'($urandom);
    burst_mode = ($urandom_range(0, 1) == 0);
    send_beat(OP_FLUSH, 16'($urandom), 16'($urandom), 1'b0);
    for (int i = 0; i < TABLE_ENTRIES + 4; i++)
      send_beat($urandom_range(0, 1) ? OP_STORE_TEMP : OP_LOAD, base + 16'(i),
                16'($urandom), 1'b0);
    send_beat(OP_LOAD, base + 16'(TABLE_ENTRIES), 16'($urandom), 1'b0);      // was dropped
    send_beat(OP_LOAD, base, 16'($urandom), 1'b0);                            // first entry
    send_beat(OP_LOAD, base + 16'(TABLE_ENTRIES - 1), 16'($urandom), 1'b0);  // last entry
    send_beat(OP_STORE_OTHER, base + 16'd5, 16'($urandom), 1'b0);
    send_beat(OP_STORE_TEMP, base + 16'(TABLE_ENTRIES + 9), 16'($urandom), 1'b0);
    send_beat(OP_LOAD, base + 16'd5, 16'($urandom), 1'b0);                    // dead, no room
    send_beat(OP_LOAD, base + 16'd6, 16'($urandom), 1'b1);
  endtask

  initial begin
    rst              = 1'b1;
    start            = 1'b0;
    opcode           = OP_OTHER;
    slot_offset      = '0;
    temp_id          = '0;
    last_of_function = 1'b0;
    burst_mode       = 1'b0;
    fill_done        = 1'b0;
    random_items     = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every opcode, hit/miss/update/invalidate,
    // end of function and flush clearing the table.
    send_beat(OP_OTHER, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_LOAD, 16'h8000, 16'hFFFF, 1'b0);         // miss on empty table
    send_beat(OP_LOAD, 16'h8000, 16'h0001, 1'b0);         // hit, dest now cached
    send_beat(OP_STORE_TEMP, 16'h7FFF, 16'hFFFF, 1'b0);   // append
    send_beat(OP_LOAD, 16'h7FFF, 16'h1234, 1'b0);
    send_beat(OP_STORE_TEMP, 16'h7FFF, 16'h0000, 1'b0);   // update in place
    send_beat(OP_LOAD, 16'h7FFF, 16'h0005, 1'b0);
    send_beat(OP_STORE_OTHER, 16'h7FFF, 16'hFFFF, 1'b0);  // invalidate
    send_beat(OP_LOAD, 16'h7FFF, 16'h0007, 1'b0);         // miss past dead entry
    send_beat(OP_LOAD, 16'h7FFF, 16'h0008, 1'b0);         // hits the new entry
    send_beat(OP_STORE_OTHER, 16'h0064, 16'h0000, 1'b0);  // no match
    send_beat(3'd5, 16'h8000, 16'hFFFF, 1'b0);
    send_beat(3'd6, 16'h7FFF, 16'hAAAA, 1'b0);
    send_beat(3'd7, 16'hFFFF, 16'h5555, 1'b1);            // end of function
    send_beat(OP_LOAD, 16'h8000, 16'h0002, 1'b0);         // miss after clear
    send_beat(OP_LOAD, 16'h8000, 16'h0003, 1'b1);         // hit, then clear
    send_beat(OP_LOAD, 16'h8000, 16'h0004, 1'b0);
    send_beat(OP_FLUSH, 16'h8000, 16'hFFFF, 1'b1);        // flush with end of function
    send_beat(OP_LOAD, 16'h8000, 16'hAAAA, 1'b0);
    send_beat(OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_LOAD, 16'h8000, 16'h5555, 1'b0);
    send_beat(OP_STORE_TEMP, 16'hFFFF, 16'h5555, 1'b0);
    send_beat(OP_LOAD, 16'hFFFF, 16'hAAAA, 1'b1);
    drain();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (!fill_done && random_items >= 100) begin
        fill_table();
        fill_done = 1'b1;
      end else begin
        run_function();
      end
      if ($urandom_range(0, 7) == 0) drain();
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
